// ----- hdl/i2cm_pkg.sv -----
package i2cm_pkg;

  // Field widths
  localparam int unsigned OP_W      = 3;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned DLY_W     = 11;
  localparam int unsigned TMO_W     = 16;
  localparam int unsigned BIT_IDX_W = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Register defaults
  localparam logic [7:0]  TICKS_PER_UNIT_RST = 8'd1;
  localparam logic [15:0] ACK_TIMEOUT_RST    = 16'd250;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_UNIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT    = 1'd1;

  // Command codes
  localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OP_W-1:0] OP_START = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  // Bus sequencer phases
  typedef enum logic [14:0] {
    PH_IDLE    = 15'b000000000000001,
    PH_START_A = 15'b000000000000010,
    PH_START_B = 15'b000000000000100,
    PH_STOP_A  = 15'b000000000001000,
    PH_STOP_B  = 15'b000000000010000,
    PH_W_SETUP = 15'b000000000100000,
    PH_W_HIGH  = 15'b000000001000000,
    PH_W_LOW   = 15'b000000010000000,
    PH_WA_A    = 15'b000000100000000,
    PH_WA_B    = 15'b000001000000000,
    PH_WA_POLL = 15'b000010000000000,
    PH_R_LOW   = 15'b000100000000000,
    PH_R_HIGH  = 15'b001000000000000,
    PH_A_LOW   = 15'b010000000000000,
    PH_A_HIGH  = 15'b100000000000000
  } phase_t;

  typedef struct packed {
    logic [7:0]  ticks_per_delay_unit;
    logic [15:0] ack_timeout_limit;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] tx_byte;
    logic              send_ack;
    logic              sda_in;
  } req_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic              sda_driving;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              no_ack;
  } res_t;

endpackage

// ----- hdl/i2cm_req_if.sv -----
interface i2cm_req_if import i2cm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] tx_byte;
  logic              send_ack;
  logic              sda_in;

  modport source (output valid, operation, tx_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, operation, tx_byte, send_ack, sda_in, output ready);
endinterface

// ----- hdl/i2cm_res_if.sv -----
interface i2cm_res_if import i2cm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              scl_level;
  logic              sda_level;
  logic              sda_driving;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] rx_byte;
  logic              no_ack;

  modport source (output valid, scl_level, sda_level, sda_driving, busy_res, done_res,
                  rx_byte, no_ack, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_driving, busy_res, done_res,
                  rx_byte, no_ack, output ready);
endinterface

// ----- hdl/i2c_bus_master_core.sv -----
// Channel  Dir  Contents
// req      in   operation, tx_byte, send_ack, sda_in (one bus tick per request)
// res      out  scl_level, sda_level, sda_driving, busy_res, done_res, rx_byte, no_ack
// cfg      in   cfg_wr_en, cfg_index, cfg_data (0 ticks per delay unit, 1 ack timeout)
//
// One request per clock unless stalled; its result is registered in the output register.
// The sequencer state advances in the same cycle the request is taken.
// A new request is taken whenever the output register is empty or being drained.
// Synchronous active-high reset; bus lines come out of reset high and driven.
module i2c_bus_master_core import i2cm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  i2cm_req_if.sink              req,
  i2cm_res_if.source            res,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  req_t  req_data;
  res_t  res_next;
  res_t  res_data;
  logic  res_valid;
  logic  step;

  assign req.ready = ~res_valid | res.ready;
  assign step      = req.valid & req.ready;

  assign req_data.operation = req.operation;
  assign req_data.tx_byte   = req.tx_byte;
  assign req_data.send_ack  = req.send_ack;
  assign req_data.sda_in    = req.sda_in;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_delay_unit <= TICKS_PER_UNIT_RST;
      cfg.ack_timeout_limit    <= ACK_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TICKS_PER_UNIT: cfg.ticks_per_delay_unit <= cfg_data[7:0];
        REG_ACK_TIMEOUT:    cfg.ack_timeout_limit    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  i2cm_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .req  (req_data),
    .cfg  (cfg),
    .res  (res_next)
  );

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_data <= res_next;
    end
  end

  assign res.valid       = res_valid;
  assign res.scl_level   = res_data.scl_level;
  assign res.sda_level   = res_data.sda_level;
  assign res.sda_driving = res_data.sda_driving;
  assign res.busy_res    = res_data.busy_res;
  assign res.done_res    = res_data.done_res;
  assign res.rx_byte     = res_data.rx_byte;
  assign res.no_ack      = res_data.no_ack;

endmodule

// ----- hdl/i2cm_seq.sv -----
module i2cm_seq import i2cm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  req_t req,
  input  cfg_t cfg,
  output res_t res
);

  phase_t                phase, phase_next;
  logic [BIT_IDX_W-1:0]  bit_index, bit_index_next;
  logic [BYTE_W-1:0]     shift_data, shift_data_next;
  logic [DLY_W-1:0]      delay_count, delay_count_next;
  logic [TMO_W-1:0]      timeout_count, timeout_count_next;
  logic                  ack_choice, ack_choice_next;
  logic                  scl_reg, scl_reg_next;
  logic                  sda_reg, sda_reg_next;
  logic                  sda_dir, sda_dir_next;
  logic [BYTE_W-1:0]     rx_reg, rx_reg_next;
  logic                  nack_flag, nack_flag_next;
  logic                  done;

  logic [7:0]            unit;
  logic [DLY_W-1:0]      dly1, dly2, dly4, dly_dec;
  logic [BIT_IDX_W-1:0]  bit_inc;

  // Hold lengths of 1, 2 and 4 units; a zero unit acts as one tick
  assign unit    = (cfg.ticks_per_delay_unit == 8'd0) ? 8'd1 : cfg.ticks_per_delay_unit;
  assign dly1    = {3'b000, unit};
  assign dly2    = {2'b00, unit, 1'b0};
  assign dly4    = {1'b0, unit, 2'b00};
  assign dly_dec = (delay_count != '0) ? delay_count - 1'b1 : '0;
  assign bit_inc = bit_index + 1'b1;

  // Next state for one tick
  always_comb begin
    phase_next         = phase;
    bit_index_next     = bit_index;
    shift_data_next    = shift_data;
    delay_count_next   = delay_count;
    timeout_count_next = timeout_count;
    ack_choice_next    = ack_choice;
    scl_reg_next       = scl_reg;
    sda_reg_next       = sda_reg;
    sda_dir_next       = sda_dir;
    rx_reg_next        = rx_reg;
    nack_flag_next     = nack_flag;
    done               = 1'b0;

    if (phase == PH_IDLE) begin
      case (req.operation)
        OP_START: begin
          sda_dir_next     = 1'b1;
          sda_reg_next     = 1'b1;
          scl_reg_next     = 1'b1;
          phase_next       = PH_START_A;
          delay_count_next = dly4;
        end
        OP_STOP: begin
          sda_dir_next     = 1'b1;
          scl_reg_next     = 1'b0;
          sda_reg_next     = 1'b0;
          phase_next       = PH_STOP_A;
          delay_count_next = dly4;
        end
        OP_WRITE: begin
          sda_dir_next     = 1'b1;
          scl_reg_next     = 1'b0;
          nack_flag_next   = 1'b0;
          bit_index_next   = '0;
          sda_reg_next     = req.tx_byte[7];
          shift_data_next  = {req.tx_byte[6:0], 1'b0};
          phase_next       = PH_W_SETUP;
          delay_count_next = dly2;
        end
        OP_READ: begin
          sda_dir_next     = 1'b0;
          sda_reg_next     = 1'b1;
          scl_reg_next     = 1'b0;
          ack_choice_next  = req.send_ack;
          shift_data_next  = '0;
          bit_index_next   = '0;
          phase_next       = PH_R_LOW;
          delay_count_next = dly2;
        end
        default: begin
        end
      endcase
    end else if (phase == PH_WA_POLL) begin
      // Wait for the slave to pull SDA low; on timeout flag a NACK and send a STOP
      if (!req.sda_in) begin
        scl_reg_next   = 1'b0;
        nack_flag_next = 1'b0;
        phase_next     = PH_IDLE;
        done           = 1'b1;
      end else if (timeout_count >= cfg.ack_timeout_limit) begin
        nack_flag_next   = 1'b1;
        sda_dir_next     = 1'b1;
        scl_reg_next     = 1'b0;
        sda_reg_next     = 1'b0;
        phase_next       = PH_STOP_A;
        delay_count_next = dly4;
      end else begin
        timeout_count_next = timeout_count + 1'b1;
      end
    end else begin
      delay_count_next = dly_dec;
      if (dly_dec == '0) begin
        case (phase)
          PH_START_A: begin
            sda_reg_next     = 1'b0;
            phase_next       = PH_START_B;
            delay_count_next = dly4;
          end
          PH_START_B: begin
            scl_reg_next = 1'b0;
            phase_next   = PH_IDLE;
            done         = 1'b1;
          end
          PH_STOP_A: begin
            scl_reg_next     = 1'b1;
            sda_reg_next     = 1'b1;
            phase_next       = PH_STOP_B;
            delay_count_next = dly4;
          end
          PH_STOP_B: begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
          PH_W_SETUP: begin
            scl_reg_next     = 1'b1;
            phase_next       = PH_W_HIGH;
            delay_count_next = dly2;
          end
          PH_W_HIGH: begin
            scl_reg_next     = 1'b0;
            phase_next       = PH_W_LOW;
            delay_count_next = dly2;
          end
          PH_W_LOW: begin
            bit_index_next = bit_inc;
            if (bit_inc < 4'd8) begin
              sda_reg_next     = shift_data[7];
              shift_data_next  = {shift_data[6:0], 1'b0};
              phase_next       = PH_W_SETUP;
              delay_count_next = dly2;
            end else begin
              // Release SDA for the acknowledge bit
              sda_dir_next     = 1'b0;
              sda_reg_next     = 1'b1;
              phase_next       = PH_WA_A;
              delay_count_next = dly1;
            end
          end
          PH_WA_A: begin
            scl_reg_next     = 1'b1;
            phase_next       = PH_WA_B;
            delay_count_next = dly1;
          end
          PH_WA_B: begin
            timeout_count_next = '0;
            phase_next         = PH_WA_POLL;
          end
          PH_R_LOW: begin
            scl_reg_next     = 1'b1;
            shift_data_next  = {shift_data[6:0], req.sda_in};
            phase_next       = PH_R_HIGH;
            delay_count_next = dly1;
          end
          PH_R_HIGH: begin
            bit_index_next = bit_inc;
            scl_reg_next   = 1'b0;
            if (bit_inc < 4'd8) begin
              phase_next       = PH_R_LOW;
              delay_count_next = dly2;
            end else begin
              // Byte complete: drive ACK or NACK
              rx_reg_next      = shift_data;
              sda_dir_next     = 1'b1;
              sda_reg_next     = ~ack_choice;
              phase_next       = PH_A_LOW;
              delay_count_next = dly2;
            end
          end
          PH_A_LOW: begin
            scl_reg_next     = 1'b1;
            phase_next       = PH_A_HIGH;
            delay_count_next = dly2;
          end
          PH_A_HIGH: begin
            scl_reg_next = 1'b0;
            phase_next   = PH_IDLE;
            done         = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Result of this tick, taken after the update
  always_comb begin
    res.scl_level   = scl_reg_next;
    res.sda_level   = sda_dir_next ? sda_reg_next : 1'b1;
    res.sda_driving = sda_dir_next;
    res.busy_res    = (phase_next != PH_IDLE);
    res.done_res    = done;
    res.rx_byte     = rx_reg_next;
    res.no_ack      = nack_flag_next;
  end

  // Advance the sequencer on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_index     <= '0;
      shift_data    <= '0;
      delay_count   <= '0;
      timeout_count <= '0;
      ack_choice    <= 1'b0;
      scl_reg       <= 1'b1;
      sda_reg       <= 1'b1;
      sda_dir       <= 1'b1;
      rx_reg        <= '0;
      nack_flag     <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      bit_index     <= bit_index_next;
      shift_data    <= shift_data_next;
      delay_count   <= delay_count_next;
      timeout_count <= timeout_count_next;
      ack_choice    <= ack_choice_next;
      scl_reg       <= scl_reg_next;
      sda_reg       <= sda_reg_next;
      sda_dir       <= sda_dir_next;
      rx_reg        <= rx_reg_next;
      nack_flag     <= nack_flag_next;
    end
  end

endmodule

// ----- tb/sv/i2cm_bus_checker.sv -----
`timescale 1ns / 1ps
module i2cm_bus_checker import i2cm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  i2cm_req_if                   req,
  i2cm_res_if                   res,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  model_busy,
  output int unsigned           outstanding,
  output int unsigned           fail_count,
  output int unsigned           checked_count
);

  // Shadow copy of the registers
  logic [7:0]  unit_ticks;
  logic [15:0] tmo_limit;

  // Shadow copy of the bus sequencer
  phase_t             ph;
  logic [3:0]         bit_cnt;
  logic [BYTE_W-1:0]  shreg;
  logic [DLY_W-1:0]   dly;
  logic [TMO_W-1:0]   tmo_cnt;
  logic               ack_sel;
  logic               scl_q;
  logic               sda_q;
  logic               sda_oe;
  logic [BYTE_W-1:0]  rx_q;
  logic               nack_q;

  // Line states predicted for requests taken but not yet seen on the result side
  res_t line_state_q[$];
  int unsigned fail_n;
  int unsigned checked_n;

  function automatic void clear_sequencer();
    unit_ticks = TICKS_PER_UNIT_RST;
    tmo_limit  = ACK_TIMEOUT_RST;
    ph      = PH_IDLE;
    bit_cnt = '0;
    shreg   = '0;
    dly     = '0;
    tmo_cnt = '0;
    ack_sel = 1'b0;
    scl_q   = 1'b1;
    sda_q   = 1'b1;
    sda_oe  = 1'b1;
    rx_q    = '0;
    nack_q  = 1'b0;
  endfunction

  // Enter a phase and load its hold time; a zero unit counts as one tick
  function automatic void hold_for(phase_t nxt, int unsigned units);
    int unsigned u;
    u = (unit_ticks == 0) ? 1 : unit_ticks;
    ph = nxt;
    dly = DLY_W'(units * u);
  endfunction

  function automatic void launch_stop();
    sda_oe = 1'b1;
    scl_q  = 1'b0;
    sda_q  = 1'b0;
    hold_for(PH_STOP_A, 4);
  endfunction

  // Put the next data bit on SDA, MSB first
  function automatic void shift_out();
    sda_q = shreg[7];
    shreg = {shreg[6:0], 1'b0};
    hold_for(PH_W_SETUP, 2);
  endfunction

  // Advance the sequencer by one tick and return the line state after it
  function automatic res_t advance_bus_tick(logic [OP_W-1:0] op, logic [BYTE_W-1:0] tx,
                                            logic ack, logic sda);
    res_t r;
    logic fin;
    fin = 1'b0;
    if (ph == PH_IDLE) begin
      case (op)
        OP_START: begin
          sda_oe = 1'b1;
          sda_q  = 1'b1;
          scl_q  = 1'b1;
          hold_for(PH_START_A, 4);
        end
        OP_STOP: launch_stop();
        OP_WRITE: begin
          sda_oe  = 1'b1;
          scl_q   = 1'b0;
          nack_q  = 1'b0;
          shreg   = tx;
          bit_cnt = '0;
          shift_out();
        end
        OP_READ: begin
          sda_oe  = 1'b0;
          sda_q   = 1'b1;
          scl_q   = 1'b0;
          ack_sel = ack;
          shreg   = '0;
          bit_cnt = '0;
          hold_for(PH_R_LOW, 2);
        end
        default: ;
      endcase
    end else if (ph == PH_WA_POLL) begin
      // Low SDA is the acknowledge; too many high samples give up with a STOP
      if (!sda) begin
        scl_q  = 1'b0;
        nack_q = 1'b0;
        ph     = PH_IDLE;
        fin    = 1'b1;
      end else if (tmo_cnt >= tmo_limit) begin
        nack_q = 1'b1;
        launch_stop();
      end else begin
        tmo_cnt++;
      end
    end else begin
      if (dly != 0) dly--;
      if (dly == 0) begin
        case (ph)
          PH_START_A: begin
            sda_q = 1'b0;
            hold_for(PH_START_B, 4);
          end
          PH_START_B: begin
            scl_q = 1'b0;
            ph    = PH_IDLE;
            fin   = 1'b1;
          end
          PH_STOP_A: begin
            scl_q = 1'b1;
            sda_q = 1'b1;
            hold_for(PH_STOP_B, 4);
          end
          PH_STOP_B: begin
            ph  = PH_IDLE;
            fin = 1'b1;
          end
          PH_W_SETUP: begin
            scl_q = 1'b1;
            hold_for(PH_W_HIGH, 2);
          end
          PH_W_HIGH: begin
            scl_q = 1'b0;
            hold_for(PH_W_LOW, 2);
          end
          PH_W_LOW: begin
            bit_cnt++;
            if (bit_cnt < 8) begin
              shift_out();
            end else begin
              // Release SDA for the slave's acknowledge
              sda_oe = 1'b0;
              sda_q  = 1'b1;
              hold_for(PH_WA_A, 1);
            end
          end
          PH_WA_A: begin
            scl_q = 1'b1;
            hold_for(PH_WA_B, 1);
          end
          PH_WA_B: begin
            tmo_cnt = '0;
            ph      = PH_WA_POLL;
          end
          PH_R_LOW: begin
            scl_q = 1'b1;
            shreg = {shreg[6:0], sda};
            hold_for(PH_R_HIGH, 1);
          end
          PH_R_HIGH: begin
            bit_cnt++;
            scl_q = 1'b0;
            if (bit_cnt < 8) begin
              hold_for(PH_R_LOW, 2);
            end else begin
              // Latch the byte and drive ACK or NACK
              rx_q   = shreg;
              sda_oe = 1'b1;
              sda_q  = ~ack_sel;
              hold_for(PH_A_LOW, 2);
            end
          end
          PH_A_LOW: begin
            scl_q = 1'b1;
            hold_for(PH_A_HIGH, 2);
          end
          PH_A_HIGH: begin
            scl_q = 1'b0;
            ph    = PH_IDLE;
            fin   = 1'b1;
          end
          default: ph = PH_IDLE;
        endcase
      end
    end

    r.scl_level   = scl_q;
    r.sda_level   = sda_oe ? sda_q : 1'b1;
    r.sda_driving = sda_oe;
    r.busy_res    = (ph != PH_IDLE);
    r.done_res    = fin;
    r.rx_byte     = rx_q;
    r.no_ack      = nack_q;
    return r;
  endfunction

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", fname, want, got);
      fail_n++;
    end
  endfunction

  // Match results first, then take the register write and the new request
  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (rst) begin
      clear_sequencer();
      line_state_q.delete();
      fail_n    = 0;
      checked_n = 0;
    end else begin
      if (res.valid && res.ready) begin
        got.scl_level   = res.scl_level;
        got.sda_level   = res.sda_level;
        got.sda_driving = res.sda_driving;
        got.busy_res    = res.busy_res;
        got.done_res    = res.done_res;
        got.rx_byte     = res.rx_byte;
        got.no_ack      = res.no_ack;
        if (line_state_q.size() == 0) begin
          $error("result with no request waiting for it");
          fail_n++;
        end else begin
          want = line_state_q.pop_front();
          check_field("scl_level", want.scl_level, got.scl_level);
          check_field("sda_level", want.sda_level, got.sda_level);
          check_field("sda_driving", want.sda_driving, got.sda_driving);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          check_field("rx_byte", want.rx_byte, got.rx_byte);
          check_field("no_ack", want.no_ack, got.no_ack);
          checked_n++;
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == REG_TICKS_PER_UNIT) unit_ticks = cfg_data[7:0];
        else if (cfg_index == REG_ACK_TIMEOUT) tmo_limit = cfg_data;
      end
      if (req.valid && req.ready)
        line_state_q.push_back(advance_bus_tick(req.operation, req.tx_byte, req.send_ack,
                                                req.sda_in));
    end
    model_busy    <= (ph != PH_IDLE);
    outstanding   <= line_state_q.size();
    fail_count    <= fail_n;
    checked_count <= checked_n;
  end

endmodule

// ----- tb/sv/i2c_bus_master_core_tb.sv -----
`timescale 1ns / 1ps
module i2c_bus_master_core_tb;
  import i2cm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_STALL     = 300;
  localparam int unsigned SETTLE_CYCLES  = 4;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  logic        stall_token;
  int unsigned cmd_count;

  logic        model_busy;
  int unsigned outstanding;
  int unsigned fail_count;
  int unsigned checked_count;

  i2cm_req_if req ();
  i2cm_res_if res ();

  i2c_bus_master_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res       (res),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  i2cm_bus_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .res           (res),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .model_busy    (model_busy),
    .outstanding   (outstanding),
    .fail_count    (fail_count),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : rx_ready_gen
    logic        seen;
    int unsigned quiet;
    seen  = 1'b0;
    quiet = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (quiet != 0) begin
        quiet--;
        res.ready <= 1'b0;
      end else if (stall_token != seen) begin
        seen  = stall_token;
        quiet = LONG_STALL;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Abort when neither channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (res.valid && res.ready)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic sda_draw(int unsigned high_pct);
    return ($urandom_range(0, 99) < high_pct);
  endfunction

  // Offer one request after a random gap and hold it until taken
  task automatic send_req(logic [OP_W-1:0] op, logic [BYTE_W-1:0] tx, logic ack, logic sda);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.tx_byte   <= tx;
    req.send_ack  <= ack;
    req.sda_in    <= sda;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // Issue a command, then tick until the sequencer is idle again
  task automatic run_cmd(logic [OP_W-1:0] op, logic [BYTE_W-1:0] tx, logic ack,
                         int unsigned high_pct);
    send_req(op, tx, ack, sda_draw(high_pct));
    do
      send_req(OP_TICK, BYTE_W'($urandom), 1'($urandom), sda_draw(high_pct));
    while (model_busy);
    cmd_count++;
  endtask

  // Drop valid and wait for every predicted result to come out
  task automatic drain_results();
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Finish any bus command with SDA low, drain, then write both registers
  task automatic reconfigure(logic [7:0] unit, logic [15:0] limit);
    do
      send_req(OP_TICK, BYTE_W'($urandom), 1'($urandom), 1'b0);
    while (model_busy);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_TICKS_PER_UNIT;
    cfg_data  <= CFG_DATA_W'(unit);
    @(posedge clk);
    cfg_index <= REG_ACK_TIMEOUT;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly whole commands with ticks between, some stray commands while busy
  task automatic random_traffic(int unsigned n);
    logic [OP_W-1:0] op;
    int unsigned     bias;
    logic            fresh;
    bias  = 50;
    fresh = 1'b0;
    for (int unsigned k = 0; k < n; k++) begin
      op = OP_TICK;
      if (!model_busy && !fresh && $urandom_range(0, 99) < 50) begin
        if ($urandom_range(0, 9) == 0)
          op = OP_W'($urandom_range(OP_READ + 1, (1 << OP_W) - 1));
        else
          op = OP_W'($urandom_range(OP_START, OP_READ));
        case ($urandom_range(0, 3))
          0: bias = 0;
          1: bias = 50;
          2: bias = 90;
          default: bias = 100;
        endcase
      end else if ($urandom_range(0, 99) < 4) begin
        op = OP_W'($urandom);
      end
      if (op >= OP_START && op <= OP_READ) cmd_count++;
      fresh = (op != OP_TICK);
      send_req(op, BYTE_W'($urandom), 1'($urandom), sda_draw(bias));
    end
  endtask

  initial begin
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.operation <= OP_TICK;
    req.tx_byte   <= '0;
    req.send_ack  <= 1'b0;
    req.sda_in    <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= REG_TICKS_PER_UNIT;
    cfg_data      <= '0;
    tx_idle_pct   <= 0;
    rx_stall_pct  <= 0;
    stall_token   <= 1'b0;
    cmd_count     = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: default registers
    run_cmd(OP_START, 8'h00, 1'b0, 50);
    run_cmd(OP_WRITE, 8'hA5, 1'b0, 0);
    run_cmd(OP_READ, 8'h00, 1'b1, 100);
    run_cmd(OP_READ, 8'hFF, 1'b0, 0);
    for (int c = OP_READ + 1; c < (1 << OP_W); c++)
      send_req(OP_W'(c), 8'hFF, 1'b1, 1'b1);
    // Command arriving while a START is still running
    send_req(OP_START, 8'h00, 1'b0, 1'b1);
    run_cmd(OP_READ, 8'h3C, 1'b1, 50);
    run_cmd(OP_STOP, 8'h00, 1'b0, 50);

    // Directed: zero delay unit and zero timeout
    reconfigure(8'd0, 16'd0);
    run_cmd(OP_WRITE, 8'h81, 1'b0, 100);
    run_cmd(OP_STOP, 8'h00, 1'b1, 50);

    // Directed: doubled hold scale and longest acknowledge wait
    reconfigure(8'd2, 16'd65535);
    run_cmd(OP_WRITE, 8'hC3, 1'b0, 50);
    run_cmd(OP_READ, 8'h5A, 1'b1, 50);

    // Random phases, one per idling pattern
    reconfigure(8'd1, 16'd3);
    random_traffic(64);

    reconfigure(8'd2, 16'd1);
    tx_idle_pct <= 86;
    random_traffic(64);

    reconfigure(8'd3, 16'd12);
    tx_idle_pct  <= 0;
    rx_stall_pct <= 86;
    random_traffic(64);

    reconfigure(8'd1, 16'd6);
    tx_idle_pct  <= 11;
    rx_stall_pct <= 11;
    stall_token  <= ~stall_token;
    random_traffic(64);

    reconfigure(8'd0, 16'd0);
    tx_idle_pct  <= 0;
    rx_stall_pct <= 0;
    random_traffic(64);

    drain_results();
    $display("Ran %0d bus commands, checked %0d line states per tick", cmd_count,
             checked_count);
    $display("Hold scales 0 to 3, acknowledge limits 0 to 65535, with stalls on both sides");
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
